FILE: hdl/rsd_pkg.sv
package rsd_pkg;

    // Header signature and header byte positions
    localparam logic [7:0] HDR_CHAR_R = 8'h52;
    localparam logic [7:0] HDR_CHAR_L = 8'h4C;
    localparam logic [7:0] HDR_CHAR_E = 8'h45;
    localparam int HDR_IDX_R   = 0;
    localparam int HDR_IDX_L   = 1;
    localparam int HDR_IDX_E   = 2;
    localparam int HDR_IDX_ACT = 3;
    localparam int HDR_IDX_ALT = 4;

    // Count byte that, together with the alternate sentinel, marks a swap
    localparam logic [7:0] SWAP_COUNT = 8'd0;

    // Results caused by one input byte are capped at this number
    localparam int          RES_CNT_W   = 5;
    localparam logic [4:0]  MAX_RESULTS = 5'd23;

    // Only the first eight bytes of a point carry the distance and angle words
    localparam int BUF_KEEP = 8;
    localparam int BUF_AW   = 3;

    // Command queue between the front and the back
    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    // Configuration register indexes
    localparam logic CFG_BAND_LOW  = 1'b0;
    localparam logic CFG_BAND_HIGH = 1'b1;

    // Band reset value: 100000.0
    localparam logic [31:0] BAND_RESET = 32'h47C3_5000;

    // IEEE single field masks: exponent, fraction, magnitude and sign
    localparam logic [31:0] EXP_MASK  = 32'h7F80_0000;
    localparam logic [31:0] FRAC_MASK = 32'h007F_FFFF;
    localparam logic [31:0] MAG_MASK  = 32'h7FFF_FFFF;
    localparam logic [31:0] SIGN_MASK = 32'h8000_0000;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_BODY,
        PH_ESC1,
        PH_ESC2,
        PH_SKIP
    } phase_t;

    typedef enum logic {
        BK_IDLE,
        BK_RUN
    } bk_state_t;

    // One classified request: push value count times, then close the packet if last
    typedef struct packed {
        logic [7:0] value;
        logic [7:0] count;
        logic       last;
        logic       status;
    } cmd_t;

    typedef struct packed {
        logic        is_point;
        logic [31:0] distance;
        logic [31:0] angle;
        logic        point_valid;
        logic        packet_done;
        logic        packet_status;
    } res_t;

endpackage

FILE: hdl/rsd_front.sv
module rsd_front #(
    parameter int HEADER_LEN = 9
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,   // [7:0] data_byte
    input  logic          s_tlast,   // packet_last
    input  logic          q_full,
    output logic          q_push,
    output rsd_pkg::cmd_t q_cmd
);

    localparam int HIW = $clog2(HEADER_LEN);

    rsd_pkg::phase_t phase_reg, phase_next;
    logic [HIW-1:0]  hidx_reg, hidx_next;
    logic            bad_reg, bad_next;
    logic [7:0]      act_reg, act_next;
    logic [7:0]      alt_reg, alt_next;
    logic [7:0]      esc_reg, esc_next;

    logic            accept;
    logic [HIW:0]    hidx_inc;
    logic            hdr_done;
    logic            hdr_mismatch;
    logic            bad_upd;
    logic            is_act;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign hidx_inc = {1'b0, hidx_reg} + (HIW+1)'(1);
    assign hdr_done = (hidx_inc == (HIW+1)'(HEADER_LEN));
    assign is_act   = (s_tdata == act_reg);

    // Compare the signature bytes
    always_comb begin
        hdr_mismatch = 1'b0;
        if (hidx_reg == HIW'(rsd_pkg::HDR_IDX_R) && s_tdata != rsd_pkg::HDR_CHAR_R) begin
            hdr_mismatch = 1'b1;
        end
        if (hidx_reg == HIW'(rsd_pkg::HDR_IDX_L) && s_tdata != rsd_pkg::HDR_CHAR_L) begin
            hdr_mismatch = 1'b1;
        end
        if (hidx_reg == HIW'(rsd_pkg::HDR_IDX_E) && s_tdata != rsd_pkg::HDR_CHAR_E) begin
            hdr_mismatch = 1'b1;
        end
    end

    assign bad_upd = bad_reg || hdr_mismatch;

    // Next state
    always_comb begin
        phase_next = phase_reg;
        hidx_next  = hidx_reg;
        bad_next   = bad_reg;
        act_next   = act_reg;
        alt_next   = alt_reg;
        esc_next   = esc_reg;
        if (accept) begin
            case (phase_reg)
                rsd_pkg::PH_HEADER: begin
                    bad_next  = bad_upd;
                    hidx_next = hidx_inc[HIW-1:0];
                    if (hidx_reg == HIW'(rsd_pkg::HDR_IDX_ACT)) begin
                        act_next = s_tdata;
                    end
                    if (hidx_reg == HIW'(rsd_pkg::HDR_IDX_ALT)) begin
                        alt_next = s_tdata;
                    end
                    if (hdr_done) begin
                        phase_next = bad_upd ? rsd_pkg::PH_SKIP : rsd_pkg::PH_BODY;
                    end
                end
                rsd_pkg::PH_BODY: begin
                    if (is_act) begin
                        phase_next = rsd_pkg::PH_ESC1;
                    end
                end
                rsd_pkg::PH_ESC1: begin
                    esc_next   = s_tdata;
                    phase_next = rsd_pkg::PH_ESC2;
                end
                rsd_pkg::PH_ESC2: begin
                    phase_next = rsd_pkg::PH_BODY;
                    if (esc_reg == rsd_pkg::SWAP_COUNT && s_tdata == alt_reg) begin
                        act_next = alt_reg;
                        alt_next = act_reg;
                    end
                end
                default: begin
                    phase_next = phase_reg;
                end
            endcase
            // Return to the reset state at the packet end
            if (s_tlast) begin
                phase_next = rsd_pkg::PH_HEADER;
                hidx_next  = '0;
                bad_next   = 1'b0;
                act_next   = '0;
                alt_next   = '0;
                esc_next   = '0;
            end
        end
    end

    // Classify the byte into a request for the back
    always_comb begin
        q_cmd.value  = s_tdata;
        q_cmd.count  = 8'd0;
        q_cmd.last   = s_tlast;
        q_cmd.status = 1'b0;
        case (phase_reg)
            rsd_pkg::PH_HEADER: begin
                q_cmd.status = bad_upd || (!hdr_done && s_tlast);
            end
            rsd_pkg::PH_BODY: begin
                q_cmd.count = is_act ? 8'd0 : 8'd1;
            end
            rsd_pkg::PH_ESC1: begin
                // An escape cut short treats this byte as an ordinary one
                q_cmd.count = (s_tlast && !is_act) ? 8'd1 : 8'd0;
            end
            rsd_pkg::PH_ESC2: begin
                if (!(esc_reg == rsd_pkg::SWAP_COUNT && s_tdata == alt_reg)) begin
                    q_cmd.count = esc_reg;
                end
            end
            default: begin
                q_cmd.status = 1'b1;
            end
        endcase
        q_push = accept && (q_cmd.count != 8'd0 || s_tlast);
    end

    // Hold the decoder state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= rsd_pkg::PH_HEADER;
            hidx_reg  <= '0;
            bad_reg   <= 1'b0;
            act_reg   <= '0;
            alt_reg   <= '0;
            esc_reg   <= '0;
        end else begin
            phase_reg <= phase_next;
            hidx_reg  <= hidx_next;
            bad_reg   <= bad_next;
            act_reg   <= act_next;
            alt_reg   <= alt_next;
            esc_reg   <= esc_next;
        end
    end

endmodule

FILE: hdl/rsd_cmd_fifo.sv
module rsd_cmd_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  rsd_pkg::cmd_t push_cmd,
    input  logic          pop,
    output rsd_pkg::cmd_t head_cmd,
    output logic          full,
    output logic          not_empty
);

    rsd_pkg::cmd_t            mem_reg [rsd_pkg::QDEPTH];
    logic [rsd_pkg::QAW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [rsd_pkg::QAW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [rsd_pkg::QAW:0]    cnt_reg, cnt_next;
    logic                     do_push;
    logic                     do_pop;

    assign full      = (cnt_reg == (rsd_pkg::QAW+1)'(rsd_pkg::QDEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head_cmd  = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    // Advance the pointers
    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (!do_push && do_pop) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store the request
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: hdl/rsd_back.sv
module rsd_back #(
    parameter int POINT_LEN = 12
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic [31:0]   band_low,
    input  logic [31:0]   band_high,
    input  logic          q_not_empty,
    input  rsd_pkg::cmd_t q_cmd,
    output logic          q_pop,
    output logic          m_valid,
    input  logic          m_ready,
    output rsd_pkg::res_t m_res,
    output logic          m_last
);

    localparam int FW = $clog2(POINT_LEN);

    rsd_pkg::bk_state_t          state_reg, state_next;
    logic [7:0]                  val_reg, val_next;
    logic [7:0]                  left_reg, left_next;
    logic                        last_reg, last_next;
    logic                        status_reg, status_next;
    logic [rsd_pkg::RES_CNT_W-1:0] rcnt_reg, rcnt_next;
    logic [FW-1:0]               fill_reg, fill_next;
    logic [7:0]                  buf_reg [rsd_pkg::BUF_KEEP];
    logic                        pend_v_reg, pend_v_next;
    rsd_pkg::res_t               pend_reg, pend_next;
    logic                        m_valid_reg, m_valid_next;
    rsd_pkg::res_t               m_res_reg, m_res_next;
    logic                        m_last_reg, m_last_next;

    logic                        do_push;
    logic                        do_status;
    logic                        do_flush;
    logic                        pt_complete;
    logic                        finite;
    logic                        in_band;
    logic [31:0]                 dist_w;
    logic [31:0]                 ang_w;
    logic [7:0]                  pb;
    logic                        has_res;
    logic                        emit;
    logic                        out_free;
    logic                        stall;
    logic                        go;
    logic                        buf_wr;
    rsd_pkg::res_t               new_res;

    function automatic logic is_nan(input logic [31:0] x);
        is_nan = ((x & rsd_pkg::EXP_MASK) == rsd_pkg::EXP_MASK) &&
                 ((x & rsd_pkg::FRAC_MASK) != 32'd0);
    endfunction

    // Map an IEEE single onto an unsigned order, folding -0 onto +0
    function automatic logic [31:0] order_key(input logic [31:0] x);
        logic [31:0] y;
        y = ((x & rsd_pkg::MAG_MASK) == 32'd0) ? 32'd0 : x;
        order_key = y[31] ? ~y : (y | rsd_pkg::SIGN_MASK);
    endfunction

    assign do_push   = (state_reg == rsd_pkg::BK_RUN) && (left_reg != 8'd0);
    assign do_status = (state_reg == rsd_pkg::BK_RUN) && (left_reg == 8'd0) && last_reg;
    assign do_flush  = (state_reg == rsd_pkg::BK_RUN) && (left_reg == 8'd0) && !last_reg;
    assign pt_complete = do_push && (fill_reg == FW'(POINT_LEN - 1));
    assign out_free  = !m_valid_reg || m_ready;

    // Assemble the distance and angle words from the stored bytes and this byte
    always_comb begin
        dist_w = '0;
        ang_w  = '0;
        for (int j = 0; j < 8; j++) begin
            pb = (j == POINT_LEN - 1) ? val_reg : buf_reg[j];
            if (j < 4) begin
                dist_w[8*j +: 8] = pb;
            end else begin
                ang_w[8*(j-4) +: 8] = pb;
            end
        end
    end

    assign finite  = ((dist_w & rsd_pkg::EXP_MASK) != rsd_pkg::EXP_MASK) &&
                     ((ang_w & rsd_pkg::EXP_MASK) != rsd_pkg::EXP_MASK);
    assign in_band = !is_nan(band_low) && !is_nan(band_high) &&
                     (order_key(band_low) <= order_key(dist_w)) &&
                     (order_key(dist_w) <= order_key(band_high));

    // Form the candidate result of this cycle
    always_comb begin
        new_res = '0;
        has_res = 1'b0;
        if (pt_complete && finite) begin
            has_res              = 1'b1;
            new_res.is_point     = 1'b1;
            new_res.distance     = dist_w;
            new_res.angle        = ang_w;
            new_res.point_valid  = !in_band;
        end else if (do_status) begin
            has_res               = 1'b1;
            new_res.packet_done   = 1'b1;
            new_res.packet_status = status_reg;
        end
    end

    assign emit  = has_res && (rcnt_reg < rsd_pkg::MAX_RESULTS);
    assign stall = pend_v_reg && !out_free && (emit || do_flush);
    assign go    = !stall;
    assign q_pop = q_not_empty && ((state_reg == rsd_pkg::BK_IDLE) || (do_flush && go));
    assign buf_wr = do_push && go && (int'(fill_reg) < rsd_pkg::BUF_KEEP);

    // Advance the run, the point framer and the result holding stages
    always_comb begin
        state_next   = state_reg;
        val_next     = val_reg;
        left_next    = left_reg;
        last_next    = last_reg;
        status_next  = status_reg;
        rcnt_next    = rcnt_reg;
        fill_next    = fill_reg;
        pend_v_next  = pend_v_reg;
        pend_next    = pend_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_res_next   = m_res_reg;
        m_last_next  = m_last_reg;

        if (go) begin
            if (do_push) begin
                left_next = left_reg - 8'd1;
                fill_next = pt_complete ? '0 : fill_reg + 1'b1;
            end
            if (do_status) begin
                last_next = 1'b0;
                fill_next = '0;
            end
            // Retire the held result: early when another follows, as last on flush
            if (pend_v_reg && (emit || do_flush)) begin
                m_valid_next = 1'b1;
                m_res_next   = pend_reg;
                m_last_next  = do_flush;
                pend_v_next  = 1'b0;
            end
            if (emit) begin
                pend_v_next = 1'b1;
                pend_next   = new_res;
                rcnt_next   = rcnt_reg + 1'b1;
            end
            if (do_flush) begin
                state_next = rsd_pkg::BK_IDLE;
            end
        end

        // Load the next request
        if (q_pop) begin
            state_next  = rsd_pkg::BK_RUN;
            val_next    = q_cmd.value;
            left_next   = q_cmd.count;
            last_next   = q_cmd.last;
            status_next = q_cmd.status;
            rcnt_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rsd_pkg::BK_IDLE;
            left_reg    <= '0;
            last_reg    <= 1'b0;
            rcnt_reg    <= '0;
            fill_reg    <= '0;
            pend_v_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            left_reg    <= left_next;
            last_reg    <= last_next;
            rcnt_reg    <= rcnt_next;
            fill_reg    <= fill_next;
            pend_v_reg  <= pend_v_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        val_reg    <= val_next;
        status_reg <= status_next;
        pend_reg   <= pend_next;
        m_res_reg  <= m_res_next;
        m_last_reg <= m_last_next;
        if (buf_wr) begin
            buf_reg[fill_reg[rsd_pkg::BUF_AW-1:0]] <= val_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_res   = m_res_reg;
    assign m_last  = m_last_reg;

`ifndef SYNTHESIS
    a_rcnt_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        rcnt_reg <= rsd_pkg::MAX_RESULTS)
        else $error("result count above cap");

    a_fill_range: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(fill_reg) < POINT_LEN)
        else $error("point fill out of range");

    a_status_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_res_reg.packet_done |-> m_last_reg)
        else $error("status item not marked last");

    a_kind_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_res_reg.is_point != m_res_reg.packet_done))
        else $error("result is neither point nor status");

    a_idle_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == rsd_pkg::BK_IDLE) |-> !pend_v_reg)
        else $error("held result left behind at idle");
`endif

endmodule

FILE: hdl/rle_scan_point_decoder_unit.sv
// Output: a point result waits in a holding register and moves to the m_ registers once
// the next result of its byte or the close of that byte's work is known.
// Flow: the back takes the decompressed bytes in turn, closes each input byte that has work
// in a separate step and ends a packet with a status item; a four-entry request queue lets
// the front take one byte per cycle meanwhile, while that queue is not full.
// Reset: aresetn is synchronous, active low; band registers return to 100000.0.
module rle_scan_point_decoder_unit #(
    parameter int HEADER_LEN = 9,
    parameter int POINT_LEN  = 12
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] data_byte
    input  logic        s_tlast,     // packet_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,     // [31:0] distance_bits, [63:32] angle_bits,
                                     // [64] point_valid, [65] packet_status, zero fill
    output logic [1:0]  m_tuser,     // [0] is_point, [1] packet_done
    output logic        m_tlast,     // run_last
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [31:0] cfg_wr_data
);

    logic [31:0]   band_low_reg;
    logic [31:0]   band_high_reg;
    logic          q_full;
    logic          q_push;
    logic          q_pop;
    logic          q_not_empty;
    rsd_pkg::cmd_t front_cmd;
    rsd_pkg::cmd_t head_cmd;
    rsd_pkg::res_t res;

    // Hold the band registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            band_low_reg  <= rsd_pkg::BAND_RESET;
            band_high_reg <= rsd_pkg::BAND_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                rsd_pkg::CFG_BAND_LOW:  band_low_reg  <= cfg_wr_data;
                rsd_pkg::CFG_BAND_HIGH: band_high_reg <= cfg_wr_data;
                default: begin
                    band_low_reg <= band_low_reg;
                end
            endcase
        end
    end

    rsd_front #(
        .HEADER_LEN (HEADER_LEN)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (front_cmd)
    );

    rsd_cmd_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_cmd  (front_cmd),
        .pop       (q_pop),
        .head_cmd  (head_cmd),
        .full      (q_full),
        .not_empty (q_not_empty)
    );

    rsd_back #(
        .POINT_LEN (POINT_LEN)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .band_low    (band_low_reg),
        .band_high   (band_high_reg),
        .q_not_empty (q_not_empty),
        .q_cmd       (head_cmd),
        .q_pop       (q_pop),
        .m_valid     (m_tvalid),
        .m_ready     (m_tready),
        .m_res       (res),
        .m_last      (m_tlast)
    );

    // Pack the result
    assign m_tdata = {6'd0, res.packet_status, res.point_valid, res.angle, res.distance};
    assign m_tuser = {res.packet_done, res.is_point};

endmodule
